/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked outside reset only
`define LANT_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");
// checked at every edge, reset included
`define LANT_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");
`else
`define LANT_ASSERT(label, clk, rst, prop)
`define LANT_ASSERT_RST(label, clk, prop)
`endif
`endif

/* rtl/lant_pkg.sv */
// ----------------------------------------------------------------------------
// lant_pkg
// Shared constants, codes and types of the Langton's ant grid stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package lant_pkg;

  // parameter defaults
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;
  localparam int MAX_ANTS_DEF   = 8;

  // port field widths
  localparam int MODE_W    = 2;
  localparam int SLOT_W    = 3;
  localparam int POS_W     = 6;
  localparam int HD_W      = 2;
  localparam int DIM_CFG_W = 7;
  localparam int CNT_CFG_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;

  // commands
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PLACE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd3;

  // headings
  localparam logic [HD_W-1:0] HD_UP    = 2'd0;
  localparam logic [HD_W-1:0] HD_RIGHT = 2'd1;
  localparam logic [HD_W-1:0] HD_DOWN  = 2'd2;
  localparam logic [HD_W-1:0] HD_LEFT  = 2'd3;

  // heading increments for a turn
  localparam logic [HD_W-1:0] TURN_RIGHT = 2'd1;
  localparam logic [HD_W-1:0] TURN_LEFT  = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANT_COUNT   = 2'd2;

  // register reset values
  localparam logic [DIM_CFG_W-1:0] GRID_WIDTH_RST  = 7'd64;
  localparam logic [DIM_CFG_W-1:0] GRID_HEIGHT_RST = 7'd64;
  localparam logic [CNT_CFG_W-1:0] ANT_COUNT_RST   = 4'd1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PLACE,
    S_READ,
    S_ANT_RD,
    S_CELL_RD,
    S_CELL_WR
  } lant_state_t;

endpackage

`default_nettype wire

/* rtl/lant_ram.sv */
// ----------------------------------------------------------------------------
// lant_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lant_ram #(
  parameter int DATA_W = 1,
  parameter int DEPTH  = 2,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [AW-1:0]     raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/lant_ant_table.sv */
// ----------------------------------------------------------------------------
// lant_ant_table
// Per-ant position and heading store. A valid bit per slot makes
// slots that were never written read as zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lant_ant_table #(
  parameter int DATA_W = 14,
  parameter int DEPTH  = 8,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [AW-1:0]     raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DEPTH-1:0]  valid;
  logic              valid_q;
  logic [DATA_W-1:0] ram_rdata;

  lant_ram #(
    .DATA_W (DATA_W),
    .DEPTH  (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      // sampled with the same timing as the RAM read
      valid_q <= valid[raddr];
      if (we) begin
        valid[waddr] <= 1'b1;
      end
    end
  end

  assign rdata = valid_q ? ram_rdata : '0;

endmodule

`default_nettype wire

/* rtl/langton_ant_grid_stepper.sv */
// ----------------------------------------------------------------------------
// langton_ant_grid_stepper
// Multi-ant Langton's ant on a toroidal one-bit board kept in block RAM.
// ----------------------------------------------------------------------------
// Command interface: a command is taken on a clock edge with start high and
// busy low. mode selects tick, place ant, clear board or read cell. Every
// command returns one result: done pulses for one cycle with cell_value and
// read_out_of_range; the receiver cannot stall it.
// Steps from acceptance to the done cycle:
//   tick        an ant table read, then for each active ant a board read
//               then write-back through the registered-read board RAM,
//               overlapped with the next ant table read
//   place, read the ant table write or the board read result, then done
//   clear       every board word, MAX_WIDTH*MAX_HEIGHT, one per cycle
// busy drops in the done cycle, so a new command may start right then.
// Reset: the board is swept to zero over all MAX_WIDTH*MAX_HEIGHT words
// (4096 at defaults) with busy high and no done; ants and registers reset
// at once. Register writes (cfg_we, cfg_index, cfg_wdata) take effect at the
// edge and belong only in idle periods.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module langton_ant_grid_stepper
  import lant_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int MAX_ANTS   = MAX_ANTS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [MODE_W-1:0]    mode,
  input  wire logic [SLOT_W-1:0]    ant_index,
  input  wire logic [POS_W-1:0]     pos_x,
  input  wire logic [POS_W-1:0]     pos_y,
  input  wire logic [HD_W-1:0]      heading,
  output logic                      done,
  output logic                      cell_value,
  output logic                      read_out_of_range,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata
);

  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int YW     = $clog2(MAX_HEIGHT);
  localparam int CW     = (XW > POS_W) ? XW : POS_W;
  localparam int RW     = (YW > POS_W) ? YW : POS_W;
  localparam int DW_W   = $clog2(MAX_WIDTH + 1);
  localparam int DH_W   = $clog2(MAX_HEIGHT + 1);
  localparam int NW     = $clog2(MAX_ANTS + 1);
  localparam int AAW    = (MAX_ANTS > 1) ? $clog2(MAX_ANTS) : 1;
  localparam int AD_W   = CW + RW + HD_W;
  localparam int BDEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int BAW    = $clog2(BDEPTH);

  lant_state_t state, state_next;

  logic [DIM_CFG_W-1:0] grid_width, grid_height;
  logic [CNT_CFG_W-1:0] ant_count;
  logic [DW_W-1:0]      w_eff;
  logic [DH_W-1:0]      h_eff;
  logic [NW-1:0]        n_eff;

  logic                 accept;
  logic [BAW-1:0]       clr_addr;
  logic                 clr_report;
  logic [NW-1:0]        ant_idx, ant_next;

  logic [SLOT_W-1:0]    cmd_slot;
  logic [POS_W-1:0]     cmd_x, cmd_y;
  logic [HD_W-1:0]      cmd_hd;
  logic                 cmd_oor;
  logic                 rd_oor;
  logic [BAW-1:0]       rd_addr;

  logic [XW-1:0]        cur_x, sat_x, mv_x;
  logic [YW-1:0]        cur_y, sat_y, mv_y;
  logic [HD_W-1:0]      cur_hd, turn_hd;
  logic [BAW-1:0]       cur_addr, sat_addr;

  logic                 done_next, value_next, oor_next;

  logic                 board_we;
  logic [BAW-1:0]       board_waddr, board_raddr;
  logic [0:0]           board_wdata, board_rdata;

  logic                 ant_we;
  logic [AAW-1:0]       ant_waddr, ant_raddr;
  logic [AD_W-1:0]      ant_wdata, ant_rdata;
  logic [CW-1:0]        ant_col;
  logic [RW-1:0]        ant_row;
  logic [HD_W-1:0]      ant_hd;

  // --------------------------------------------------------------------------
  // storage
  // --------------------------------------------------------------------------
  lant_ram #(
    .DATA_W (1),
    .DEPTH  (BDEPTH)
  ) u_board (
    .clk   (clk),
    .we    (board_we),
    .waddr (board_waddr),
    .wdata (board_wdata),
    .raddr (board_raddr),
    .rdata (board_rdata)
  );

  lant_ant_table #(
    .DATA_W (AD_W),
    .DEPTH  (MAX_ANTS)
  ) u_ants (
    .clk   (clk),
    .rst   (rst),
    .we    (ant_we),
    .waddr (ant_waddr),
    .wdata (ant_wdata),
    .raddr (ant_raddr),
    .rdata (ant_rdata)
  );

  // --------------------------------------------------------------------------
  // effective grid size and ant count
  // --------------------------------------------------------------------------
  always_comb begin
    if (grid_width == '0) begin
      w_eff = DW_W'(1);
    end else if (32'(grid_width) > MAX_WIDTH) begin
      w_eff = DW_W'(MAX_WIDTH);
    end else begin
      w_eff = DW_W'(grid_width);
    end
    if (grid_height == '0) begin
      h_eff = DH_W'(1);
    end else if (32'(grid_height) > MAX_HEIGHT) begin
      h_eff = DH_W'(MAX_HEIGHT);
    end else begin
      h_eff = DH_W'(grid_height);
    end
    if (ant_count == '0) begin
      n_eff = NW'(1);
    end else if (32'(ant_count) > MAX_ANTS) begin
      n_eff = NW'(MAX_ANTS);
    end else begin
      n_eff = NW'(ant_count);
    end
  end

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign ant_next = ant_idx + 1'b1;

  // cell read command
  assign rd_oor  = (32'(pos_x) >= 32'(w_eff)) || (32'(pos_y) >= 32'(h_eff));
  assign rd_addr = BAW'(32'(pos_y) * MAX_WIDTH + 32'(pos_x));

  // --------------------------------------------------------------------------
  // ant fetch: pull a stray ant onto the last column/row, form board address
  // --------------------------------------------------------------------------
  assign ant_col = ant_rdata[AD_W-1 -: CW];
  assign ant_row = ant_rdata[HD_W +: RW];
  assign ant_hd  = ant_rdata[HD_W-1:0];

  always_comb begin
    if (32'(ant_col) >= 32'(w_eff)) begin
      sat_x = XW'(w_eff - DW_W'(1));
    end else begin
      sat_x = XW'(ant_col);
    end
    if (32'(ant_row) >= 32'(h_eff)) begin
      sat_y = YW'(h_eff - DH_W'(1));
    end else begin
      sat_y = YW'(ant_row);
    end
    sat_addr = BAW'(32'(sat_y) * MAX_WIDTH + 32'(sat_x));
  end

  // --------------------------------------------------------------------------
  // turn and step with wraparound
  // --------------------------------------------------------------------------
  always_comb begin
    turn_hd = board_rdata[0] ? cur_hd + TURN_RIGHT : cur_hd + TURN_LEFT;
    mv_x    = cur_x;
    mv_y    = cur_y;
    unique case (turn_hd)
      HD_UP: begin
        mv_y = (cur_y == '0) ? YW'(h_eff - DH_W'(1)) : cur_y - 1'b1;
      end
      HD_RIGHT: begin
        mv_x = (32'(cur_x) + 32'd1 >= 32'(w_eff)) ? '0 : cur_x + 1'b1;
      end
      HD_DOWN: begin
        mv_y = (32'(cur_y) + 32'd1 >= 32'(h_eff)) ? '0 : cur_y + 1'b1;
      end
      HD_LEFT: begin
        mv_x = (cur_x == '0) ? XW'(w_eff - DW_W'(1)) : cur_x - 1'b1;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_next  = state;
    done_next   = 1'b0;
    value_next  = 1'b0;
    oor_next    = 1'b0;
    board_we    = 1'b0;
    board_waddr = clr_addr;
    board_wdata = 1'b0;
    board_raddr = (state == S_CELL_RD) ? sat_addr : rd_addr;
    ant_we      = 1'b0;
    ant_waddr   = ant_idx[AAW-1:0];
    ant_wdata   = {CW'(mv_x), RW'(mv_y), turn_hd};
    // next ant is fetched while the current one is written back
    ant_raddr   = (state == S_CELL_WR) ? ant_next[AAW-1:0] : ant_idx[AAW-1:0];

    unique case (state)
      S_CLEAR: begin
        board_we = 1'b1;
        if (clr_addr == BAW'(BDEPTH - 1)) begin
          state_next = S_IDLE;
          done_next  = clr_report;
        end
      end
      S_IDLE: begin
        if (start) begin
          unique case (mode)
            MODE_TICK:  state_next = S_ANT_RD;
            MODE_PLACE: state_next = S_PLACE;
            MODE_CLEAR: state_next = S_CLEAR;
            MODE_READ:  state_next = S_READ;
          endcase
        end
      end
      S_PLACE: begin
        ant_we     = (32'(cmd_slot) < MAX_ANTS);
        ant_waddr  = AAW'(cmd_slot);
        ant_wdata  = {CW'(cmd_x), RW'(cmd_y), cmd_hd};
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      S_READ: begin
        done_next  = 1'b1;
        value_next = !cmd_oor && board_rdata[0];
        oor_next   = cmd_oor;
        state_next = S_IDLE;
      end
      S_ANT_RD: begin
        state_next = S_CELL_RD;
      end
      S_CELL_RD: begin
        state_next = S_CELL_WR;
      end
      S_CELL_WR: begin
        board_we    = 1'b1;
        board_waddr = cur_addr;
        board_wdata = ~board_rdata;
        ant_we      = 1'b1;
        if (32'(ant_next) >= 32'(n_eff)) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_CELL_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_CLEAR;
      clr_addr          <= '0;
      clr_report        <= 1'b0;
      ant_idx           <= '0;
      done              <= 1'b0;
      cell_value        <= 1'b0;
      read_out_of_range <= 1'b0;
      grid_width        <= GRID_WIDTH_RST;
      grid_height       <= GRID_HEIGHT_RST;
      ant_count         <= ANT_COUNT_RST;
    end else begin
      state             <= state_next;
      done              <= done_next;
      cell_value        <= value_next;
      read_out_of_range <= oor_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GRID_WIDTH:  grid_width  <= cfg_wdata;
          CFG_GRID_HEIGHT: grid_height <= cfg_wdata;
          CFG_ANT_COUNT:   ant_count   <= cfg_wdata[CNT_CFG_W-1:0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        clr_addr   <= '0;
        clr_report <= 1'b1;
        ant_idx    <= '0;
      end else begin
        if (state == S_CLEAR) begin
          clr_addr <= clr_addr + 1'b1;
        end
        if (state == S_CELL_WR) begin
          ant_idx <= ant_next;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_slot <= ant_index;
      cmd_x    <= pos_x;
      cmd_y    <= pos_y;
      cmd_hd   <= heading;
      cmd_oor  <= rd_oor;
    end
    if (state == S_CELL_RD) begin
      cur_x    <= sat_x;
      cur_y    <= sat_y;
      cur_hd   <= ant_hd;
      cur_addr <= sat_addr;
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `LANT_ASSERT(a_done_when_idle, clk, rst, done |-> !busy)
  `LANT_ASSERT(a_done_after_work, clk, rst, done |-> $past(busy))
  `LANT_ASSERT(a_accept_goes_busy, clk, rst, (start && !busy) |=> busy)
  `LANT_ASSERT(a_oor_reads_zero, clk, rst, read_out_of_range |-> !cell_value)
  `LANT_ASSERT_RST(a_reset_sweeps, clk, rst |=> (busy && !done))

endmodule

`default_nettype wire

/* tb/sv/tb_langton_ant_grid_stepper.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_langton_ant_grid_stepper
// Self-checking bench for the multi-ant toroidal grid stepper. A short table
// of commands covers extremes, clamping and out-of-grid reads. Random
// commands follow over several grid and ant settings. Every result is
// compared with a behavioral model of board and ants or a table row's value.
// ----------------------------------------------------------------------------

module tb_langton_ant_grid_stepper;
  import lant_pkg::*;

  localparam int GRID_COLS   = MAX_WIDTH_DEF;
  localparam int GRID_ROWS   = MAX_HEIGHT_DEF;
  localparam int ANT_SLOTS   = MAX_ANTS_DEF;
  localparam int GRID_CELLS  = GRID_COLS * GRID_ROWS;
  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 24;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 50;
  localparam int MAX_CLEARS  = 16;
  localparam int DIR_ROWS    = 32;

  // index past the register list, written to check it is ignored
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_NONE = 2'd3;

  typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [HD_W-1:0]   hd;
  } board_cmd_t;

  typedef struct packed {
    logic val;
    logic oor;
  } cell_result_t;

  typedef struct packed {
    row_kind_t             kind;
    board_cmd_t            cmd;
    logic                  typed;
    logic                  val;
    logic                  oor;
    logic [CFG_IDX_W-1:0]  cidx;
    logic [CFG_DAT_W-1:0]  cdat;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic [MODE_W-1:0]    mode = MODE_TICK;
  logic [SLOT_W-1:0]    ant_index = '0;
  logic [POS_W-1:0]     pos_x = '0;
  logic [POS_W-1:0]     pos_y = '0;
  logic [HD_W-1:0]      heading = HD_UP;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_GRID_WIDTH;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;
  logic                 busy;
  logic                 done;
  logic                 cell_value;
  logic                 read_out_of_range;

  // model of the block
  bit                   board [GRID_CELLS];
  bit [POS_W-1:0]       ant_x [ANT_SLOTS];
  bit [POS_W-1:0]       ant_y [ANT_SLOTS];
  bit [HD_W-1:0]        ant_dir [ANT_SLOTS];
  bit [DIM_CFG_W-1:0]   reg_width = GRID_WIDTH_RST;
  bit [DIM_CFG_W-1:0]   reg_height = GRID_HEIGHT_RST;
  bit [CNT_CFG_W-1:0]   reg_count = ANT_COUNT_RST;

  cell_result_t cell_results_due [$];
  int err_count = 0;
  int cycle_count = 0;

  int phase_w [PHASES] = '{8, 1, 64, 0, 5, 16, 127, 2, 12};
  int phase_h [PHASES] = '{8, 1, 64, 127, 3, 16, 0, 64, 9};
  int phase_n [PHASES] = '{4, 8, 8, 2, 15, 3, 0, 8, 22};

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_CMD, '{MODE_READ,  3'd0, 6'd0,  6'd0,  HD_UP},    1'b1, 1'b0, 1'b0, CFG_GRID_WIDTH, 7'd0},
    '{ROW_CMD, '{MODE_READ,  3'd0, 6'd63, 6'd63, HD_UP},    1'b1, 1'b0, 1'b0, CFG_GRID_WIDTH, 7'd0},
    '{ROW_CMD, '{MODE_TICK,  3'd0, 6'd0,  6'd0,  HD_UP},    1'b0, 1'b0, 1'b0, CFG_GRID_WIDTH, 7'd0},
    '{ROW_CMD, '{MODE_READ,  3'd0, 6'd0,  6'd0,  HD_UP},    1'b0, 1'b0, 1'b0, CFG_GRID_WIDTH, 7'd0},
    '{ROW_CMD, '{MODE_TICK,  3'd0, 6'd0,  6'd0,  HD_UP},    1'b0, 1'b0, 1'b0, CFG_GRID_WIDTH, 7'd0},
    '{ROW_CMD, '{MODE_READ,  3'd0, 6'd63, 6'd0,  HD_UP},    1'b0, 1'b0, 1'b0, CFG_GRID_WIDTH, 7'd0},
    '{ROW_CMD, '{MODE_PLACE, 3'd7, 6'd63, 6'd63, HD_LEFT},  1'b0, 1'b0, 1'b0, CFG_GRID_WIDTH, 7'd0},
    '{ROW_CMD, '{MODE_PLACE, 3'd0, 6'd0,  6'd0,  HD_DOWN},  1'b0, 1'b0, 1'b0, CFG_GRID_WIDTH, 7'd0},
    '{ROW_CFG, '{MODE_TICK,  3'd0, 6'd0,  6'd0,  HD_UP},    1'b0, 1'b0, 1'b0, CFG_ANT_COUNT,  7'd8},
    '{ROW_CMD, '{MODE_TICK,  3'd0, 6'd0,  6'd0,  HD_UP},    1'b0, 1'b0, 1'b0, CFG_GRID_WIDTH, 7'd0},
    '{ROW_CMD, '{MODE_READ,  3'd0, 6'd63, 6'd63, HD_UP},    1'b0, 1'b0, 1'b0, CFG_GRID_WIDTH, 7'd0},
    '{ROW_CFG, '{MODE_TICK,  3'd0, 6'd0,  6'd0,  HD_UP},    1'b0, 1'b0, 1'b0, CFG_GRID_WIDTH, 7'd4},
    '{ROW_CFG, '{MODE_TICK,  3'd0, 6'd0,  6'd0,  HD_UP},    1'b0, 1'b0, 1'b0, CFG_GRID_HEIGHT, 7'd3},
    '{ROW_CMD, '{MODE_READ,  3'd0, 6'd4,  6'd0,  HD_UP},    1'b1, 1'b0, 1'b1, CFG_GRID_WIDTH, 7'd0},
    '{ROW_CMD, '{MODE_READ,  3'd0, 6'd0,  6'd3,  HD_UP},    1'b1, 1'b0, 1'b1, CFG_GRID_WIDTH, 7'd0},
    '{ROW_CMD, '{MODE_READ,  3'd0, 6'd63, 6'd63, HD_UP},    1'b1, 1'b0, 1'b1, CFG_GRID_WIDTH, 7'd0},
    // slot 7 sits outside the 4x3 grid: pulled onto the last column
    '{ROW_CMD, '{MODE_TICK,  3'd0, 6'd0,  6'd0,  HD_UP},    1'b0, 1'b0, 1'b0, CFG_GRID_WIDTH, 7'd0},
    '{ROW_CMD, '{MODE_READ,  3'd0, 6'd3,  6'd2,  HD_UP},    1'b0, 1'b0, 1'b0, CFG_GRID_WIDTH, 7'd0},
    '{ROW_CMD, '{MODE_READ,  3'd0, 6'd0,  6'd0,  HD_UP},    1'b0, 1'b0, 1'b0, CFG_GRID_WIDTH, 7'd0},
    '{ROW_CMD, '{MODE_PLACE, 3'd3, 6'd62, 6'd1,  HD_RIGHT}, 1'b0, 1'b0, 1'b0, CFG_GRID_WIDTH, 7'd0},
    '{ROW_CMD, '{MODE_TICK,  3'd0, 6'd0,  6'd0,  HD_UP},    1'b0, 1'b0, 1'b0, CFG_GRID_WIDTH, 7'd0},
    '{ROW_CMD, '{MODE_CLEAR, 3'd0, 6'd0,  6'd0,  HD_UP},    1'b1, 1'b0, 1'b0, CFG_GRID_WIDTH, 7'd0},
    '{ROW_CMD, '{MODE_READ,  3'd0, 6'd0,  6'd0,  HD_UP},    1'b1, 1'b0, 1'b0, CFG_GRID_WIDTH, 7'd0},
    '{ROW_CFG, '{MODE_TICK,  3'd0, 6'd0,  6'd0,  HD_UP},    1'b0, 1'b0, 1'b0, CFG_GRID_WIDTH, 7'd0},
    '{ROW_CFG, '{MODE_TICK,  3'd0, 6'd0,  6'd0,  HD_UP},    1'b0, 1'b0, 1'b0, CFG_GRID_HEIGHT, 7'd127},
    '{ROW_CFG, '{MODE_TICK,  3'd0, 6'd0,  6'd0,  HD_UP},    1'b0, 1'b0, 1'b0, CFG_ANT_COUNT,  7'd0},
    '{ROW_CFG, '{MODE_TICK,  3'd0, 6'd0,  6'd0,  HD_UP},    1'b0, 1'b0, 1'b0, CFG_IDX_NONE,   7'h55},
    '{ROW_CMD, '{MODE_TICK,  3'd0, 6'd0,  6'd0,  HD_UP},    1'b0, 1'b0, 1'b0, CFG_GRID_WIDTH, 7'd0},
    '{ROW_CMD, '{MODE_READ,  3'd0, 6'd1,  6'd0,  HD_UP},    1'b1, 1'b0, 1'b1, CFG_GRID_WIDTH, 7'd0},
    '{ROW_CMD, '{MODE_READ,  3'd0, 6'd0,  6'd5,  HD_UP},    1'b0, 1'b0, 1'b0, CFG_GRID_WIDTH, 7'd0},
    '{ROW_CFG, '{MODE_TICK,  3'd0, 6'd0,  6'd0,  HD_UP},    1'b0, 1'b0, 1'b0, CFG_ANT_COUNT,  7'd15},
    '{ROW_CMD, '{MODE_TICK,  3'd0, 6'd0,  6'd0,  HD_UP},    1'b0, 1'b0, 1'b0, CFG_GRID_WIDTH, 7'd0}
  };

  langton_ant_grid_stepper u_dut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .mode              (mode),
    .ant_index         (ant_index),
    .pos_x             (pos_x),
    .pos_y             (pos_y),
    .heading           (heading),
    .done              (done),
    .cell_value        (cell_value),
    .read_out_of_range (read_out_of_range),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH @%0t: %s got %0d want %0d", $time, what, got, want);
    err_count++;
  endtask

  function automatic int clamp_dim(input int v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Applies one command to the board model and returns its result.
  function automatic cell_result_t step_board(input board_cmd_t c);
    cell_result_t r;
    int w, h, n, x, y, cell_idx;
    logic [HD_W-1:0] d;
    r = '0;
    w = clamp_dim(int'(reg_width), GRID_COLS);
    h = clamp_dim(int'(reg_height), GRID_ROWS);
    n = clamp_dim(int'(reg_count), ANT_SLOTS);
    case (c.mode)
      MODE_TICK: begin
        for (int i = 0; i < n; i++) begin
          x = int'(ant_x[i]);
          y = int'(ant_y[i]);
          d = ant_dir[i];
          if (x >= w) x = w - 1;
          if (y >= h) y = h - 1;
          cell_idx = y * GRID_COLS + x;
          if (board[cell_idx]) begin
            d = d + TURN_RIGHT;
            board[cell_idx] = 1'b0;
          end else begin
            d = d + TURN_LEFT;
            board[cell_idx] = 1'b1;
          end
          case (d)
            HD_UP:    y = (y == 0) ? h - 1 : y - 1;
            HD_RIGHT: x = (x + 1 >= w) ? 0 : x + 1;
            HD_DOWN:  y = (y + 1 >= h) ? 0 : y + 1;
            default:  x = (x == 0) ? w - 1 : x - 1;
          endcase
          ant_x[i] = POS_W'(x);
          ant_y[i] = POS_W'(y);
          ant_dir[i] = d;
        end
      end
      MODE_PLACE: begin
        ant_x[c.slot] = c.x;
        ant_y[c.slot] = c.y;
        ant_dir[c.slot] = c.hd;
      end
      MODE_CLEAR: begin
        foreach (board[k]) board[k] = 1'b0;
      end
      default: begin
        if (int'(c.x) >= w || int'(c.y) >= h) r.oor = 1'b1;
        else r.val = board[int'(c.y) * GRID_COLS + int'(c.x)];
      end
    endcase
    return r;
  endfunction

  // Holds the command until the block takes it, then books its result.
  task automatic issue_command(input board_cmd_t c, input logic typed,
                               input logic tval, input logic toor);
    cell_result_t r;
    start <= 1'b1;
    mode <= c.mode;
    ant_index <= c.slot;
    pos_x <= c.x;
    pos_y <= c.y;
    heading <= c.hd;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = step_board(c);
    if (typed) begin
      r.val = tval;
      r.oor = toor;
    end
    cell_results_due.push_back(r);
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (cell_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_GRID_WIDTH:  reg_width = data;
      CFG_GRID_HEIGHT: reg_height = data;
      CFG_ANT_COUNT:   reg_count = data[CNT_CFG_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    cell_result_t want;
    if (!rst && done) begin
      if (cell_results_due.size() == 0) begin
        report_mismatch("result with no command pending: cell_value",
                        int'(cell_value), 0);
      end else begin
        want = cell_results_due.pop_front();
        if (cell_value !== want.val)
          report_mismatch("cell_value", int'(cell_value), int'(want.val));
        if (read_out_of_range !== want.oor)
          report_mismatch("read_out_of_range", int'(read_out_of_range), int'(want.oor));
      end
    end
  end

  initial begin : stimulus
    board_cmd_t c;
    int w_eff, h_eff, idle_pct, sel, clears;
    clears = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].kind == ROW_CFG)
        write_reg(dir_rows[r].cidx, dir_rows[r].cdat);
      else
        issue_command(dir_rows[r].cmd, dir_rows[r].typed, dir_rows[r].val, dir_rows[r].oor);
    end

    // random phases, one grid/ant setting each
    for (int p = 0; p < PHASES; p++) begin
      write_reg(CFG_GRID_WIDTH, CFG_DAT_W'(phase_w[p]));
      write_reg(CFG_GRID_HEIGHT, CFG_DAT_W'(phase_h[p]));
      write_reg(CFG_ANT_COUNT, CFG_DAT_W'(phase_n[p]));
      if (p == 4) write_reg(CFG_IDX_NONE, CFG_DAT_W'($urandom_range(127)));
      w_eff = clamp_dim(int'(reg_width), GRID_COLS);
      h_eff = clamp_dim(int'(reg_height), GRID_ROWS);
      idle_pct = (p < 3) ? 8 : (p < 6) ? 59 : 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        c.slot = SLOT_W'($urandom_range(ANT_SLOTS - 1));
        c.x = POS_W'($urandom_range(GRID_COLS - 1));
        c.y = POS_W'($urandom_range(GRID_ROWS - 1));
        c.hd = HD_W'($urandom_range(3));
        sel = $urandom_range(99);
        if (sel < 45) begin
          c.mode = MODE_TICK;
        end else if (sel < 97 || clears >= MAX_CLEARS) begin
          c.mode = (sel < 60) ? MODE_PLACE : MODE_READ;
          // mostly inside the grid in use
          if ($urandom_range(99) < 85) begin
            c.x = POS_W'($urandom_range(w_eff - 1));
            c.y = POS_W'($urandom_range(h_eff - 1));
          end
        end else begin
          c.mode = MODE_CLEAR;
          clears++;
        end
        issue_command(c, 1'b0, 1'b0, 1'b0);
        if (i < PHASE_ITEMS - 1 && idle_pct > 0) begin
          if ($urandom_range(39) == 0)
            drain();
          else if ($urandom_range(99) < idle_pct)
            hold_off($urandom_range(1, 24));
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
